[rtl/midi_channel_message_parser_top_defines.svh]
// Assertion macros for the MIDI channel message parser.
`ifndef MIDI_CHANNEL_MESSAGE_PARSER_TOP_DEFINES_SVH
`define MIDI_CHANNEL_MESSAGE_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MCMP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MCMP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mcmp_pkg.sv]
// Types, byte codes and decode helpers for the MIDI channel message parser.
package mcmp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned VALUE_W = 7;

  localparam logic [BYTE_W-1:0] MSG_STATUS_BIT  = 8'b1000_0000;
  localparam logic [BYTE_W-1:0] MSG_TYPE_MASK   = 8'b1111_0000;
  localparam logic [BYTE_W-1:0] MSG_CLOCK       = 8'b1111_1000;
  localparam logic [BYTE_W-1:0] MSG_START       = 8'b1111_1010;
  localparam logic [BYTE_W-1:0] MSG_NOTE_OFF    = 8'b1000_0000;
  localparam logic [BYTE_W-1:0] MSG_NOTE_ON     = 8'b1001_0000;
  localparam logic [BYTE_W-1:0] MSG_POLY_AT     = 8'b1010_0000;
  localparam logic [BYTE_W-1:0] MSG_CTRL_CHANGE = 8'b1011_0000;
  localparam logic [BYTE_W-1:0] MSG_PITCH_BEND  = 8'b1110_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_NOTE_OFF    = 3'd0,
    KIND_NOTE_ON     = 3'd1,
    KIND_CTRL_CHANGE = 3'd2,
    KIND_PITCH_BEND  = 3'd3,
    KIND_CLOCK       = 3'd4,
    KIND_START       = 3'd5
  } event_kind_t;

  function automatic logic takes_two_data(input logic [BYTE_W-1:0] status);
    logic [BYTE_W-1:0] t;
    t = status & MSG_TYPE_MASK;
    return t inside {MSG_NOTE_OFF, MSG_NOTE_ON, MSG_POLY_AT, MSG_CTRL_CHANGE,
                     MSG_PITCH_BEND};
  endfunction

endpackage

[rtl/midi_channel_message_parser_top.sv]
// MIDI channel message parser with running status: byte in, event out.
//
//   channel | direction | handshake          | payload
//   in_     | in        | in_valid/in_stall   | in_rx_byte
//   out_    | out       | out_valid/out_stall | out_event_kind, out_channel,
//           |           |                     | out_first_value, out_second_value
//
// One byte per cycle while the result register is not stalled; a byte enters the input
// register at its transfer and is decoded into the result register as it advances.
// Running status and the held data byte update as a byte leaves the input register.
// Synchronous active-low reset clears both stage valids and the parser state.
// in_stall rises only when a byte that yields an event waits behind a stalled result.
`include "midi_channel_message_parser_top_defines.svh"

module midi_channel_message_parser_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mcmp_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mcmp_pkg::KIND_W-1:0]   out_event_kind,
  output logic [mcmp_pkg::CHAN_W-1:0]   out_channel,
  output logic [mcmp_pkg::VALUE_W-1:0]  out_first_value,
  output logic [mcmp_pkg::VALUE_W-1:0]  out_second_value
);
  import mcmp_pkg::*;

  logic                s1_valid_r;
  logic [BYTE_W-1:0]   s1_byte_r;

  logic [BYTE_W-1:0]   rs_r, rs_nxt;
  logic                have_first_r, have_first_nxt;
  logic [VALUE_W-1:0]  held_r, held_nxt;

  logic                out_valid_r;
  event_kind_t         kind_r, kind_nxt;
  logic [CHAN_W-1:0]   chan_r, chan_nxt;
  logic [VALUE_W-1:0]  v1_r, v1_nxt;
  logic [VALUE_W-1:0]  v2_r, v2_nxt;

  logic                emit;
  logic                out_free;
  logic                advance;
  logic                in_take;

  always_comb begin
    rs_nxt         = rs_r;
    have_first_nxt = have_first_r;
    held_nxt       = held_r;
    emit           = 1'b0;
    kind_nxt       = KIND_CLOCK;
    chan_nxt       = '0;
    v1_nxt         = '0;
    v2_nxt         = '0;
    if ((s1_byte_r & MSG_STATUS_BIT) != '0) begin
      have_first_nxt = 1'b0;
      held_nxt       = '0;
      if (s1_byte_r == MSG_CLOCK) begin
        rs_nxt   = '0;
        emit     = 1'b1;
        kind_nxt = KIND_CLOCK;
      end else if (s1_byte_r == MSG_START) begin
        rs_nxt   = '0;
        emit     = 1'b1;
        kind_nxt = KIND_START;
      end else begin
        rs_nxt = takes_two_data(s1_byte_r) ? s1_byte_r : '0;
      end
    end else if (rs_r != '0) begin
      if (!have_first_r) begin
        held_nxt       = s1_byte_r[VALUE_W-1:0];
        have_first_nxt = 1'b1;
      end else begin
        have_first_nxt = 1'b0;
        chan_nxt       = rs_r[CHAN_W-1:0];
        v1_nxt         = held_r;
        v2_nxt         = s1_byte_r[VALUE_W-1:0];
        case (rs_r & MSG_TYPE_MASK)
          MSG_NOTE_OFF: begin
            emit     = 1'b1;
            kind_nxt = KIND_NOTE_OFF;
          end
          MSG_NOTE_ON: begin
            emit     = 1'b1;
            kind_nxt = KIND_NOTE_ON;
          end
          MSG_CTRL_CHANGE: begin
            emit     = 1'b1;
            kind_nxt = KIND_CTRL_CHANGE;
          end
          MSG_PITCH_BEND: begin
            emit     = 1'b1;
            kind_nxt = KIND_PITCH_BEND;
          end
          default: begin
            emit = 1'b0;
          end
        endcase
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  // A byte with no event never waits on the result register.
  assign advance  = s1_valid_r && (out_free || !emit);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      rs_r         <= '0;
      have_first_r <= 1'b0;
      held_r       <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        rs_r         <= rs_nxt;
        have_first_r <= have_first_nxt;
        held_r       <= held_nxt;
      end
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
    if (advance && emit) begin
      kind_r <= kind_nxt;
      chan_r <= chan_nxt;
      v1_r   <= v1_nxt;
      v2_r   <= v2_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = kind_r;
  assign out_channel      = chan_r;
  assign out_first_value  = v1_r;
  assign out_second_value = v2_r;

  `MCMP_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall,
    out_valid_r && out_stall && s1_valid_r, "input stall without a held result")
  `MCMP_ASSERT_IMP(a_held_needs_status, clk, rst_n, have_first_r,
    rs_r[BYTE_W-1] && takes_two_data(rs_r), "data byte held with no running status")
  `MCMP_ASSERT_IMP(a_rt_payload_zero, clk, rst_n,
    out_valid_r && (kind_r == KIND_CLOCK || kind_r == KIND_START),
    chan_r == '0 && v1_r == '0 && v2_r == '0, "real-time event with nonzero payload")
  `MCMP_ASSERT_NXT(a_rt_clears_status, clk, rst_n,
    advance && (s1_byte_r == MSG_CLOCK || s1_byte_r == MSG_START),
    rs_r == '0 && !have_first_r, "real-time byte left running status set")

endmodule

[tb/sv/midi_channel_message_parser_top_test.sv]
// Self-checking testbench for the MIDI channel message parser, with a scoreboard class.
`timescale 1ns / 1ps

module midi_channel_message_parser_top_test;
  import mcmp_pkg::*;

  typedef struct packed {
    event_kind_t          kind;
    logic [CHAN_W-1:0]    chan;
    logic [VALUE_W-1:0]   first_value;
    logic [VALUE_W-1:0]   second_value;
  } midi_event_t;

  class midi_event_scoreboard;
    logic [BYTE_W-1:0]  running_status;
    bit                 have_first;
    logic [VALUE_W-1:0] held_first;
    midi_event_t        expected_events[$];
    int unsigned        fail_count;

    function new();
      running_status = '0;
      have_first = 1'b0;
      held_first = '0;
      fail_count = 0;
    endfunction

    function int unsigned outstanding();
      return expected_events.size();
    endfunction

    // Parse one accepted byte and queue the event it yields, if any.
    function void note_byte(logic [BYTE_W-1:0] b);
      midi_event_t ev;
      logic [BYTE_W-1:0] msg_type;
      ev = '0;
      if ((b & MSG_STATUS_BIT) != '0) begin
        have_first = 1'b0;
        held_first = '0;
        msg_type = b & MSG_TYPE_MASK;
        if (b == MSG_CLOCK || b == MSG_START) begin
          running_status = '0;
          ev.kind = (b == MSG_CLOCK) ? KIND_CLOCK : KIND_START;
          expected_events.push_back(ev);
        end else if (msg_type == MSG_NOTE_OFF || msg_type == MSG_NOTE_ON ||
                     msg_type == MSG_POLY_AT || msg_type == MSG_CTRL_CHANGE ||
                     msg_type == MSG_PITCH_BEND) begin
          running_status = b;
        end else begin
          running_status = '0;
        end
      end else if (running_status != '0) begin
        if (!have_first) begin
          held_first = b[VALUE_W-1:0];
          have_first = 1'b1;
        end else begin
          have_first = 1'b0;
          msg_type = running_status & MSG_TYPE_MASK;
          ev.chan = running_status[CHAN_W-1:0];
          ev.first_value = held_first;
          ev.second_value = b[VALUE_W-1:0];
          case (msg_type)
            MSG_NOTE_OFF: begin
              ev.kind = KIND_NOTE_OFF;
              expected_events.push_back(ev);
            end
            MSG_NOTE_ON: begin
              ev.kind = KIND_NOTE_ON;
              expected_events.push_back(ev);
            end
            MSG_CTRL_CHANGE: begin
              ev.kind = KIND_CTRL_CHANGE;
              expected_events.push_back(ev);
            end
            MSG_PITCH_BEND: begin
              ev.kind = KIND_PITCH_BEND;
              expected_events.push_back(ev);
            end
            default: ;
          endcase
        end
      end
    endfunction

    function void check_event(midi_event_t got);
      midi_event_t want;
      if (expected_events.size() == 0) begin
        $error("unexpected event: kind %0d channel %0d values %0d %0d",
               got.kind, got.chan, got.first_value, got.second_value);
        fail_count++;
        return;
      end
      want = expected_events.pop_front();
      if (got.kind !== want.kind) begin
        $error("event_kind: expected %0d, got %0d", want.kind, got.kind);
        fail_count++;
      end
      if (got.chan !== want.chan) begin
        $error("channel: expected %0d, got %0d", want.chan, got.chan);
        fail_count++;
      end
      if (got.first_value !== want.first_value) begin
        $error("first_value: expected %0d, got %0d", want.first_value, got.first_value);
        fail_count++;
      end
      if (got.second_value !== want.second_value) begin
        $error("second_value: expected %0d, got %0d", want.second_value, got.second_value);
        fail_count++;
      end
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 1850;
  localparam int QUIET_FROM   = 700;
  localparam int QUIET_TO     = 1000;
  localparam int HOLD_AT      = 1200;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_AT     = 1500;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   out_event_kind;
  logic [CHAN_W-1:0]   out_channel;
  logic [VALUE_W-1:0]  out_first_value;
  logic [VALUE_W-1:0]  out_second_value;

  logic                hold_off = 1'b0;
  int                  bytes_sent = 0;
  logic [BYTE_W-1:0]   byte_stream[$];
  midi_event_scoreboard sb = new();

  midi_channel_message_parser_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_channel      (out_channel),
    .out_first_value  (out_first_value),
    .out_second_value (out_second_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic bit idle_now();
    if (bytes_sent >= QUIET_FROM && bytes_sent < QUIET_TO) return 1'b0;
    return $urandom_range(99) < 23;
  endfunction

  function automatic logic [BYTE_W-1:0] channel_status();
    logic [BYTE_W-1:0] msg_type;
    case ($urandom_range(4))
      0:       msg_type = MSG_NOTE_OFF;
      1:       msg_type = MSG_NOTE_ON;
      2:       msg_type = MSG_POLY_AT;
      3:       msg_type = MSG_CTRL_CHANGE;
      default: msg_type = MSG_PITCH_BEND;
    endcase
    return msg_type | BYTE_W'($urandom_range(15));
  endfunction

  function automatic logic [BYTE_W-1:0] data_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'h7f;
      default: return BYTE_W'($urandom_range(127));
    endcase
  endfunction

  task automatic build_directed();
    logic [BYTE_W-1:0] seq[$];
    // stray data, real-time bytes, extremes, running status, poly aftertouch,
    // status cutting a pair, program change and system bytes clearing status
    seq = '{8'h40, MSG_CLOCK, MSG_START,
            8'h90, 8'h00, 8'h7f, 8'h8f, 8'h7f, 8'h00,
            8'hb5, 8'h12, 8'h34, 8'h56, 8'h78,
            8'he3, 8'h7f, 8'h7f, 8'ha2, 8'h10, 8'h20,
            8'h91, 8'h40, MSG_CLOCK, 8'h41, 8'hc0};
    byte_stream = seq;
    byte_stream.push_back(8'h11);
    byte_stream.push_back(8'hff);
    byte_stream.push_back(8'hf0);
  endtask

  task automatic build_random();
    int target;
    int pairs;
    int sel;
    target = byte_stream.size() + RANDOM_ITEMS;
    while (byte_stream.size() < target) begin
      sel = $urandom_range(99);
      if (sel < 75) begin
        byte_stream.push_back(channel_status());
        pairs = $urandom_range(1, 4);
        repeat (pairs) begin
          byte_stream.push_back(data_byte());
          if ($urandom_range(99) < 4)
            byte_stream.push_back($urandom_range(1) ? MSG_CLOCK : channel_status());
          byte_stream.push_back(data_byte());
        end
      end else if (sel < 85) begin
        byte_stream.push_back($urandom_range(1) ? MSG_CLOCK : MSG_START);
      end else if (sel < 92) begin
        byte_stream.push_back(BYTE_W'($urandom_range(8'h80, 8'hff)));
      end else begin
        byte_stream.push_back(BYTE_W'($urandom_range(255)));
      end
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  initial begin
    build_directed();
    build_random();
    do @(posedge clk); while (!rst_n);
    for (int i = 0; i < byte_stream.size(); i++) begin
      if (i == DRAIN_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
      end
      send_byte(byte_stream[i]);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Long receiver hold-off while the sender keeps offering bytes.
  initial begin
    wait (bytes_sent >= HOLD_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    midi_event_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.kind = event_kind_t'(out_event_kind);
        got.chan = out_channel;
        got.first_value = out_first_value;
        got.second_value = out_second_value;
        sb.check_event(got);
      end
      out_stall <= hold_off || idle_now();
    end
  end

endmodule
